@@ hdl/servo_status_packet_parser_macros.svh @@
// assertion macros shared by the servo status packet parser modules
// SSP_ASSERT expects clk and arst_n, SSP_ASSERT_ALWAYS only clk, in the scope where it is used
`ifndef SERVO_STATUS_PACKET_PARSER_MACROS_SVH
`define SERVO_STATUS_PACKET_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside of reset
`define SSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSP_ASSERT(lbl, prop, msg)
`define SSP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hdl/ssp_pkg.sv @@
// shared types and constants of the servo status packet parser
// no dependencies; imported by every module of the block
package ssp_pkg;

	// packet framing
	localparam logic [7:0] HDR_FIRST  = 8'hFF;
	localparam logic [7:0] HDR_SECOND = 8'hF5;

	// byte positions, saturating at the minimum packet length
	localparam logic [2:0] POS_HDR0   = 3'd0;
	localparam logic [2:0] POS_HDR1   = 3'd1;
	localparam logic [2:0] POS_ID     = 3'd2;
	localparam logic [2:0] POS_STATUS = 3'd4;
	localparam logic [2:0] POS_PARAM  = 3'd5;
	localparam logic [2:0] POS_SAT    = 3'd6;

	// verdict codes
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_SHORT    = 2'd1;
	localparam logic [1:0] ERR_HEADER   = 2'd2;
	localparam logic [1:0] ERR_CHECKSUM = 2'd3;

	// result kinds
	localparam logic KIND_PARAM   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// default queue depth between front and back (power of two, at least 2)
	localparam int QUEUE_DEPTH_DEF = 4;

	// one queued result: data0 is the parameter byte or the id, data1 the status
	typedef struct packed {
		logic       kind;
		logic [1:0] code;
		logic [7:0] data0;
		logic [7:0] data1;
	} ssp_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} ssp_q_status_t;

endpackage

@@ hdl/ssp_front.sv @@
// front end: accepts packet bytes, tracks position, header and checksum
// depends on ssp_pkg and the assertion macros header
`include "servo_status_packet_parser_macros.svh"

module ssp_front import ssp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
	input  logic          s_axis_tlast,
	input  ssp_q_status_t q_status,
	output logic          push,
	output ssp_entry_t    push_entry
);

	logic [2:0] pos_q;
	logic [7:0] sum_q;
	logic       header_good_q;
	logic [7:0] id_q;
	logic [7:0] status_q;
	logic       accept;
	logic [1:0] code;

	assign s_axis_tready = !q_status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// verdict priority: short, then header, then checksum
	always_comb begin
		if (pos_q < POS_PARAM) begin
			code = ERR_SHORT;
		end else if (!header_good_q) begin
			code = ERR_HEADER;
		end else if (~sum_q != s_axis_tdata) begin
			code = ERR_CHECKSUM;
		end else begin
			code = ERR_OK;
		end
	end

	// result entry for a parameter byte or a verdict
	always_comb begin
		push_entry.kind  = s_axis_tlast ? KIND_VERDICT : KIND_PARAM;
		push_entry.code  = s_axis_tlast ? code : ERR_OK;
		push_entry.data0 = s_axis_tlast ? id_q : s_axis_tdata;
		push_entry.data1 = s_axis_tlast ? status_q : 8'd0;
	end

	assign push = accept && (s_axis_tlast || (pos_q >= POS_PARAM));

	// packet tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= POS_HDR0;
			sum_q         <= 8'd0;
			header_good_q <= 1'b1;
		end else if (accept) begin
			if (s_axis_tlast) begin
				pos_q         <= POS_HDR0;
				sum_q         <= 8'd0;
				header_good_q <= 1'b1;
			end else begin
				case (pos_q)
					POS_HDR0: begin
						if (s_axis_tdata != HDR_FIRST) header_good_q <= 1'b0;
					end
					POS_HDR1: begin
						if (s_axis_tdata != HDR_SECOND) header_good_q <= 1'b0;
					end
					default: begin
						sum_q <= sum_q + s_axis_tdata;
					end
				endcase
				if (pos_q < POS_SAT) pos_q <= pos_q + 3'd1;
			end
		end
	end

	// id and status capture
	always_ff @(posedge clk) begin
		if (accept && !s_axis_tlast) begin
			if (pos_q == POS_ID) id_q <= s_axis_tdata;
			if (pos_q == POS_STATUS) status_q <= s_axis_tdata;
		end
	end

	`SSP_ASSERT(a_pos_sat, pos_q <= POS_SAT, "byte position beyond saturation")
	`SSP_ASSERT(a_restart, accept && s_axis_tlast |=> pos_q == POS_HDR0 && sum_q == 8'd0,
		"packet state not cleared after verdict")
	`SSP_ASSERT(a_push_full, push |-> !q_status.full, "push into a full queue")

endmodule

@@ hdl/ssp_queue.sv @@
// short result queue between front and back
// depends on ssp_pkg and the assertion macros header
`include "servo_status_packet_parser_macros.svh"

module ssp_queue import ssp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssp_entry_t    push_entry,
	input  logic          pop,
	output ssp_entry_t    pop_entry,
	output ssp_q_status_t q_status
);

	localparam int         AW        = $clog2(QUEUE_DEPTH);
	localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(QUEUE_DEPTH);

	ssp_entry_t    mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign q_status.full  = (count_q == DEPTH_CNT);
	assign q_status.empty = (count_q == '0);
	assign pop_entry      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SSP_ASSERT(a_count_range, count_q <= DEPTH_CNT, "queue count beyond depth")
	`SSP_ASSERT(a_pop_empty, pop |-> !q_status.empty, "pop from an empty queue")
	`SSP_ASSERT(a_full_empty, !(q_status.full && q_status.empty),
		"queue full and empty at once")

endmodule

@@ hdl/ssp_back.sv @@
// back end: formats queued results into the output register
// depends on ssp_pkg
module ssp_back import ssp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ssp_q_status_t q_status,
	input  ssp_entry_t    pop_entry,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata,  // [7:0] param_byte, [15:8] servo_id,
	                                     // [23:16] servo_status, [25:24] error_code
	output logic [0:0]    m_axis_tuser   // [0] kind
);

	logic        out_valid_q;
	logic [31:0] tdata_q;
	logic [0:0]  tuser_q;
	logic        verdict;
	logic        good;
	logic [7:0]  param_byte;
	logic [7:0]  servo_id;
	logic [7:0]  servo_status;
	logic [1:0]  error_code;

	assign pop = !q_status.empty && (!out_valid_q || m_axis_tready);

	// field formatting; id and status only go out on a good verdict
	always_comb begin
		verdict      = (pop_entry.kind == KIND_VERDICT);
		good         = verdict && (pop_entry.code == ERR_OK);
		param_byte   = verdict ? 8'd0 : pop_entry.data0;
		servo_id     = good ? pop_entry.data0 : 8'd0;
		servo_status = good ? pop_entry.data1 : 8'd0;
		error_code   = verdict ? pop_entry.code : ERR_OK;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			tdata_q <= {6'd0, error_code, servo_status, servo_id, param_byte};
			tuser_q <= pop_entry.kind;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

endmodule

@@ hdl/servo_status_packet_parser.sv @@
// Servo status packet parser, top level.
// Input stream: one packet byte per beat in s_axis_tdata; s_axis_tlast marks
// the final checksum byte. Header bytes 0xFF 0xF5, then id, an ignored byte,
// status, parameters, checksum (inverted 8-bit sum from the id byte on).
// Output stream: tuser 0 carries a parameter byte (bytes 5 up to the one
// before last), tuser 1 carries the verdict with id, status and error code
// (0 ok, 1 too short, 2 bad header, 3 bad checksum; id and status 0 on error).
// Bytes 0 to 4 give no output beat unless s_axis_tlast marks one of them.
// Throughput: one byte per cycle while the queue is not full. The front
// tracks the packet with a running sum and writes each result into a
// QUEUE_DEPTH-entry queue; the back moves it into the output register. When
// the receiver stalls the queue fills and s_axis_tready drops once it is full;
// no beat is lost. Reset clears the packet state, the queue and the output
// valid; the next byte is taken as byte 0 of a new packet.
// Depends on ssp_pkg, ssp_front, ssp_queue and ssp_back.
module servo_status_packet_parser import ssp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tlast,   // end_of_packet
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] param_byte, [15:8] servo_id,
	                                    // [23:16] servo_status, [25:24] error_code
	output logic [0:0]  m_axis_tuser    // [0] kind
);

	ssp_q_status_t q_status;
	ssp_entry_t    push_entry;
	ssp_entry_t    pop_entry;
	logic          push;
	logic          pop;

	// byte tracking and classification
	ssp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_status      (q_status),
		.push          (push),
		.push_entry    (push_entry)
	);

	// decoupling queue
	ssp_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_status   (q_status)
	);

	// output formatting and register
	ssp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.pop_entry     (pop_entry),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ bench/testbench.sv @@
// self-checking bench for servo_status_packet_parser: byte stream in, results out
// predicts every parameter beat and verdict from its own packet tracker
// depends on ssp_pkg and the servo_status_packet_parser rtl
module testbench import ssp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	// one expected output beat
	typedef struct packed {
		logic       kind;
		logic [7:0] param;
		logic [7:0] id;
		logic [7:0] status;
		logic [1:0] code;
	} parser_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic        s_axis_tlast = 1'b0;    // end_of_packet
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [7:0] param_byte, [15:8] servo_id,
	                                     // [23:16] servo_status, [25:24] error_code
	logic [0:0]  m_axis_tuser;           // [0] kind

	// packet tracker state of the predictor
	logic [2:0] pkt_pos = POS_HDR0;
	logic [7:0] pkt_sum = 8'h00;
	logic       pkt_hdr_ok = 1'b1;
	logic [7:0] pkt_id = 8'h00;
	logic [7:0] pkt_status = 8'h00;

	parser_result_t pending_results[$];
	int fail_count = 0;
	int bytes_sent = 0;
	int packets_sent = 0;
	int results_seen = 0;
	int verdicts_seen = 0;
	int input_stall_cycles = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_left = 0;

	servo_status_packet_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("%0t ns: timeout", $time);
		$display("Some tests failed");
		$finish;
	end

	// track one packet byte; returns 1 when the byte produces an output beat
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output parser_result_t r);
		logic [1:0] code;
		r = '0;
		if (last) begin
			if (int'(pkt_pos) + 1 < int'(POS_SAT))
				code = ERR_SHORT;
			else if (!pkt_hdr_ok)
				code = ERR_HEADER;
			else if (~pkt_sum != b)
				code = ERR_CHECKSUM;
			else
				code = ERR_OK;
			r.kind   = KIND_VERDICT;
			r.code   = code;
			r.id     = (code == ERR_OK) ? pkt_id : 8'h00;
			r.status = (code == ERR_OK) ? pkt_status : 8'h00;
			pkt_pos    = POS_HDR0;
			pkt_sum    = 8'h00;
			pkt_hdr_ok = 1'b1;
			pkt_id     = 8'h00;
			pkt_status = 8'h00;
			return 1'b1;
		end
		if (pkt_pos == POS_HDR0) begin
			if (b != HDR_FIRST) pkt_hdr_ok = 1'b0;
		end else if (pkt_pos == POS_HDR1) begin
			if (b != HDR_SECOND) pkt_hdr_ok = 1'b0;
		end else begin
			pkt_sum = pkt_sum + b;
			if (pkt_pos == POS_ID) pkt_id = b;
			if (pkt_pos == POS_STATUS) pkt_status = b;
		end
		if (pkt_pos >= POS_PARAM) begin
			r.kind  = KIND_PARAM;
			r.param = b;
		end
		if (pkt_pos < POS_SAT) begin
			pkt_pos = pkt_pos + 3'd1;
			return (pkt_pos == POS_SAT);
		end
		return 1'b1;
	endfunction

	// receiver side: long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic report_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		parser_result_t want;
		if (arst_n && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected beat, expected none, actual tdata %0h tuser %0h",
					$time, m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				report_field("kind", {7'b0, want.kind}, {7'b0, m_axis_tuser[0]});
				report_field("param_byte", want.param, m_axis_tdata[7:0]);
				report_field("servo_id", want.id, m_axis_tdata[15:8]);
				report_field("servo_status", want.status, m_axis_tdata[23:16]);
				report_field("error_code", {6'b0, want.code}, {6'b0, m_axis_tdata[25:24]});
				report_field("padding", 8'h00, {2'b0, m_axis_tdata[31:26]});
				results_seen++;
				if (want.kind == KIND_VERDICT) verdicts_seen++;
			end
		end
	end

	// offer one byte, with a random gap first, and predict on acceptance
	task automatic send_byte(input logic [7:0] b, input logic last);
		parser_result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		if (parse_byte(b, last, r)) pending_results = {pending_results, r};
	endtask

	task automatic send_packet(input byte_q_t bytes);
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
		packets_sent++;
	endtask

	// well-formed packet with a correct checksum
	function automatic byte_q_t frame_packet(input logic [7:0] id, input logic [7:0] skip,
			input logic [7:0] status, input byte_q_t params);
		byte_q_t bytes;
		logic [7:0] sum;
		bytes = {HDR_FIRST, HDR_SECOND, id, skip, status};
		bytes = {bytes, params};
		sum = 8'h00;
		for (int i = 2; i < bytes.size(); i++) sum = sum + bytes[i];
		bytes = {bytes, ~sum};
		return bytes;
	endfunction

	// extremes, every verdict code and the error precedence
	task automatic test_directed_packets();
		byte_q_t pkt;
		byte_q_t no_params;
		// single checksum byte only: too short
		send_packet('{8'h00});
		// good packet, id all ones, status zero, one parameter
		send_packet(frame_packet(8'hFF, 8'h00, 8'h00, '{8'hFF}));
		// too short wins over a bad header
		send_packet('{8'hFE, 8'h00, 8'h01, 8'h02, 8'h03});
		// second header byte off by one
		pkt = frame_packet(8'h00, 8'hAA, 8'hFF, no_params);
		pkt[1] = 8'hF4;
		send_packet(pkt);
		// checksum off in the lowest bit
		pkt = frame_packet(8'h80, 8'h55, 8'h7F, no_params);
		pkt[pkt.size() - 1] ^= 8'h01;
		send_packet(pkt);
	endtask

	// mostly valid packets with random content, mixed with corrupted ones, short ones and noise
	task automatic send_random_packet();
		byte_q_t pkt, params;
		int pick, n;
		pick = $urandom_range(99);
		if (pick < 86) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
			params = {};
			repeat (n) params = {params, 8'($urandom_range(255))};
			pkt = frame_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), params);
			if (pick >= 78)
				pkt[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
			else if (pick >= 70)
				pkt[pkt.size() - 1] ^= 8'($urandom_range(255, 1));
		end else if (pick < 93) begin
			pkt = {HDR_FIRST, HDR_SECOND, 8'h01, 8'h02, 8'h03};
			pkt = pkt[0:$urandom_range(4)];
			pkt[pkt.size() - 1] = 8'($urandom_range(255));
		end else begin
			pkt = {};
			repeat ($urandom_range(12, 1)) pkt = {pkt, 8'($urandom_range(255))};
		end
		send_packet(pkt);
	endtask

	task automatic test_random_packets();
		int src_pct[4] = '{0, 65, 0, 30};
		int sink_pct[4] = '{0, 0, 65, 30};
		int goal;
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = src_pct[p];
			sink_stall_pct = sink_pct[p];
			goal = bytes_sent + 300;
			while (bytes_sent < goal) send_random_packet();
		end
	endtask

	// receiver holds off while a long packet keeps coming, so the input stalls
	task automatic test_output_backpressure();
		byte_q_t params;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		params = {};
		repeat (40) params = {params, 8'($urandom_range(255))};
		hold_left <= 200;
		send_packet(frame_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), params));
	endtask

	initial begin
		int waited;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_packets();
		test_output_backpressure();
		test_random_packets();
		s_axis_tvalid <= 1'b0;

		// drain what is still in flight
		sink_stall_pct = 0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t ns: %0d expected beats never arrived", $time, pending_results.size());
			fail_count++;
		end

		$display("sent %0d packets in %0d bytes; checked %0d beats, %0d of them verdicts",
			packets_sent, bytes_sent, results_seen, verdicts_seen);
		$display("input held back for %0d cycles under output backpressure",
			input_stall_cycles);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
